>>> hdl/sfd_pkg.sv
// Shared types and constants for the S.BUS-style frame decoder.
// Used by sfd_unpack, sfd_emit and sbus_frame_decoder_top; depends on nothing.
package sfd_pkg;

  localparam int NUM_CHANNELS = 12;
  localparam int FRAME_BYTES  = 25;
  localparam int CH_BITS      = 11;
  localparam int POS_W        = 5;
  localparam int IDX_W        = 4;

  localparam logic [7:0] HEADER_VALUE   = 8'd15;
  localparam logic [7:0] FLAG_HIGH_MASK = 8'hf0;
  localparam logic [7:0] FAILSAFE_MASK  = 8'h08;
  localparam logic [7:0] END_VALUE      = 8'h00;

  // Byte positions within a frame.
  localparam logic [POS_W-1:0] POS_HEADER = '0;
  localparam logic [POS_W-1:0] POS_FLAGS  = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_END    = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_IDLE   = POS_W'(FRAME_BYTES);

  typedef logic [POS_W-1:0]                pos_t;
  typedef logic [IDX_W-1:0]                idx_t;
  typedef logic [CH_BITS-1:0]              chan_t;
  typedef chan_t [NUM_CHANNELS-1:0]        chan_arr_t;

  // Raised for one cycle when the end byte of a frame is taken.
  typedef struct packed {
    logic valid;
    logic ok;
    logic failsafe;
  } frame_evt_t;

endpackage

>>> hdl/sbus_frame_decoder_top.sv
// Top level of the S.BUS-style frame decoder: byte stream in, channel results out.
// Instantiates sfd_unpack and sfd_emit; uses sfd_pkg.
//
//   Channel  Direction  tdata                          tuser                   tlast
//   in_      slave      [7:0] data_byte                [0] frame_start         -
//   out_     master     [3:0] channel_index,           [0] frame_ok,           last
//                       [14:4] channel_value, [15] 0   [1] failsafe
//
// One byte is taken per cycle; each byte updates the channel store in the cycle it
// is accepted. The end byte of a frame starts a burst of twelve results (one for a
// bad frame), one per cycle unless out_tready stalls it, from a snapshot, through a
// single output register. in_tready drops only when the next byte could be an end
// byte while a burst is still draining. Reset (rst_n low, synchronous) clears the
// position, checks, channel store and output valid.
module sbus_frame_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] channel_index, [14:4] channel_value, [15] zero
  output logic [1:0]  out_tuser,  // [0] frame_ok, [1] failsafe
  output logic        out_tlast
);

  logic                accept;
  logic                at_end_pos;
  logic                busy;
  sfd_pkg::chan_arr_t  store;
  sfd_pkg::frame_evt_t evt;
  sfd_pkg::idx_t       res_index;
  sfd_pkg::chan_t      res_value;
  logic                res_ok;
  logic                res_fs;

  assign in_tready = !(busy && at_end_pos);
  assign accept    = in_tvalid && in_tready;

  sfd_unpack u_unpack (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_tdata),
    .frame_start (in_tuser),
    .at_end_pos  (at_end_pos),
    .store       (store),
    .evt         (evt)
  );

  sfd_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .evt          (evt),
    .store        (store),
    .busy         (busy),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_index    (res_index),
    .out_value    (res_value),
    .out_ok       (res_ok),
    .out_failsafe (res_fs),
    .out_last     (out_tlast)
  );

  assign out_tdata = {1'b0, res_value, res_index};
  assign out_tuser = {res_fs, res_ok};

endmodule

>>> hdl/sfd_unpack.sv
// Byte position tracking, channel bit unpacking and frame checks.
// Uses sfd_pkg; feeds frame-end events and the channel store to sfd_emit.
module sfd_unpack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  output logic               at_end_pos,
  output sfd_pkg::chan_arr_t store,
  output sfd_pkg::frame_evt_t evt
);

  sfd_pkg::pos_t     pos_r;
  sfd_pkg::pos_t     pos_nxt;
  sfd_pkg::pos_t     pos_cur;
  sfd_pkg::chan_arr_t store_r;
  logic              header_good_r;
  logic              flag_good_r;
  logic              fs_seen_r;

  assign pos_cur    = frame_start ? sfd_pkg::POS_HEADER : pos_r;
  assign at_end_pos = (pos_r == sfd_pkg::POS_END);
  assign store      = store_r;

  always_comb begin
    pos_nxt = pos_r;
    if (accept && (pos_cur != sfd_pkg::POS_IDLE)) begin
      pos_nxt = pos_cur + sfd_pkg::pos_t'(1);
    end
  end

  always_comb begin
    evt.valid    = accept && (pos_cur == sfd_pkg::POS_END);
    evt.ok       = header_good_r && flag_good_r && (data_byte == sfd_pkg::END_VALUE);
    evt.failsafe = fs_seen_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= sfd_pkg::POS_HEADER;
      header_good_r <= 1'b0;
      flag_good_r   <= 1'b0;
      fs_seen_r     <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (accept && (pos_cur == sfd_pkg::POS_HEADER)) begin
        header_good_r <= (data_byte == sfd_pkg::HEADER_VALUE);
      end
      if (accept && (pos_cur == sfd_pkg::POS_FLAGS)) begin
        flag_good_r <= ((data_byte & sfd_pkg::FLAG_HIGH_MASK) == 8'h00);
        fs_seen_r   <= ((data_byte & sfd_pkg::FAILSAFE_MASK) != 8'h00);
      end
    end
  end

  // Each channel bit has a fixed home in the frame: one byte position and one
  // bit within that byte. Bits that fall past the channels are simply unused.
  for (genvar c = 0; c < sfd_pkg::NUM_CHANNELS; c++) begin : g_chan
    for (genvar j = 0; j < sfd_pkg::CH_BITS; j++) begin : g_bit
      localparam int GBIT     = c * sfd_pkg::CH_BITS + j;
      localparam int BYTE_POS = GBIT / 8 + 1;
      localparam int BIT_POS  = GBIT % 8;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          store_r[c][j] <= 1'b0;
        end else if (accept && (pos_cur == sfd_pkg::POS_W'(BYTE_POS))) begin
          store_r[c][j] <= data_byte[BIT_POS];
        end
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= sfd_pkg::POS_IDLE)
    else $error("byte position beyond frame length");

  a_evt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    evt.valid |=> (pos_r == sfd_pkg::POS_IDLE))
    else $error("position not idle after end byte");

  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_start) |=> (pos_r == sfd_pkg::pos_t'(1)))
    else $error("start mark did not restart the frame");

endmodule

>>> hdl/sfd_emit.sv
// Result sequencer: snapshots a finished frame's channels and hands out one
// result per cycle via an output register while not stalled. Uses sfd_pkg.
module sfd_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  sfd_pkg::frame_evt_t evt,
  input  sfd_pkg::chan_arr_t  store,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_ready,
  output sfd_pkg::idx_t       out_index,
  output sfd_pkg::chan_t      out_value,
  output logic                out_ok,
  output logic                out_failsafe,
  output logic                out_last
);

  sfd_pkg::chan_arr_t snap_r;
  logic               busy_r;
  sfd_pkg::idx_t      idx_r;
  logic               ok_r;
  logic               fs_r;
  logic               out_valid_r;
  sfd_pkg::idx_t      out_index_r;
  sfd_pkg::chan_t     out_value_r;
  logic               out_ok_r;
  logic               out_fs_r;
  logic               out_last_r;
  logic               load;
  logic               last_nxt;

  assign load     = busy_r && (!out_valid_r || out_ready);
  assign last_nxt = !ok_r || (idx_r == sfd_pkg::idx_t'(sfd_pkg::NUM_CHANNELS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      ok_r        <= 1'b0;
      fs_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (evt.valid) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        ok_r   <= evt.ok;
        fs_r   <= evt.failsafe;
      end else if (load) begin
        idx_r <= idx_r + sfd_pkg::idx_t'(1);
        if (last_nxt) begin
          busy_r <= 1'b0;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (evt.valid) begin
      snap_r <= store;
    end
    if (load) begin
      out_index_r <= ok_r ? idx_r : '0;
      out_value_r <= ok_r ? snap_r[idx_r] : '0;
      out_ok_r    <= ok_r;
      out_fs_r    <= ok_r && fs_r;
      out_last_r  <= last_nxt;
    end
  end

  assign busy         = busy_r;
  assign out_valid    = out_valid_r;
  assign out_index    = out_index_r;
  assign out_value    = out_value_r;
  assign out_ok       = out_ok_r;
  assign out_failsafe = out_fs_r;
  assign out_last     = out_last_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    evt.valid |-> !busy_r)
    else $error("frame finished while the previous burst was still going");

  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_last_r && out_index_r == '0))
    else $error("bad-frame result is not a single last item");

  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_nxt && !evt.valid) |=> !busy_r)
    else $error("burst kept running after its last item");

endmodule

>>> bench/sfd_scoreboard_pkg.sv
// Scoreboard for the S.BUS-style frame decoder bench: tracks frame decoding per byte
// and checks each channel result against the oldest expectation.
// Depends on sfd_pkg for widths, byte positions and check constants.
`timescale 1ns / 100ps

package sfd_scoreboard_pkg;
  import sfd_pkg::*;

  typedef struct packed {
    idx_t  idx;
    chan_t value;
    logic  ok;
    logic  fs;
    logic  last;
  } chan_result_t;

  class frame_scoreboard;
    int           pos;
    chan_t        store [NUM_CHANNELS];
    bit           hdr_ok;
    bit           flags_ok;
    bit           fs_flag;
    chan_result_t expected_channels [$];
    int           errors;
    int           bytes_taken;
    int           results_checked;
    int           good_frames;
    int           bad_frames;
    int           ignored_bytes;

    function new();
      pos = 0;
      foreach (store[i]) store[i] = '0;
      hdr_ok = 0;
      flags_ok = 0;
      fs_flag = 0;
      errors = 0;
      bytes_taken = 0;
      results_checked = 0;
      good_frames = 0;
      bad_frames = 0;
      ignored_bytes = 0;
    endfunction

    // Advances the decoder state by one accepted byte and queues any results.
    function void take_byte(logic [7:0] b, logic st);
      int           bit_no;
      chan_result_t r;
      bytes_taken++;
      if (st) pos = 0;
      if (pos >= FRAME_BYTES) begin
        ignored_bytes++;
        return;
      end
      if (pos == int'(POS_HEADER)) begin
        hdr_ok = (b == HEADER_VALUE);
      end else if (pos < int'(POS_FLAGS)) begin
        // Bits past the last channel fall off the end of the store.
        for (int k = 0; k < 8; k++) begin
          bit_no = (pos - 1) * 8 + k;
          if (bit_no < NUM_CHANNELS * CH_BITS)
            store[bit_no / CH_BITS][bit_no % CH_BITS] = b[k];
        end
      end else if (pos == int'(POS_FLAGS)) begin
        flags_ok = ((b & FLAG_HIGH_MASK) == 8'h00);
        fs_flag  = ((b & FAILSAFE_MASK) != 8'h00);
      end else if (hdr_ok && flags_ok && b == END_VALUE) begin
        good_frames++;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          r.idx   = idx_t'(i);
          r.value = store[i];
          r.ok    = 1'b1;
          r.fs    = fs_flag;
          r.last  = (i == NUM_CHANNELS - 1);
          expected_channels.push_back(r);
        end
      end else begin
        bad_frames++;
        r = '0;
        r.last = 1'b1;
        expected_channels.push_back(r);
      end
      pos++;
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_channel(chan_result_t got);
      chan_result_t want;
      results_checked++;
      if (expected_channels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got index %0d value %0d ok %0d",
                 $time, got.idx, got.value, got.ok);
        return;
      end
      want = expected_channels.pop_front();
      compare_field("channel_index", want.idx, got.idx);
      compare_field("channel_value", want.value, got.value);
      compare_field("frame_ok", want.ok, got.ok);
      compare_field("failsafe", want.fs, got.fs);
      compare_field("last", want.last, got.last);
    endfunction

    function int pending();
      return expected_channels.size();
    endfunction
  endclass

endpackage

>>> bench/tb_sbus_frame_decoder_top.sv
// Bench top for sbus_frame_decoder_top: feeds good, broken and cut frames plus noise,
// with random idling and one long output stall. Uses sfd_pkg and sfd_scoreboard_pkg.
`timescale 1ns / 100ps

module tb_sbus_frame_decoder_top;
  import sfd_pkg::*;
  import sfd_scoreboard_pkg::*;

  localparam int ITEM_TARGET = 460;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {
    FRM_GOOD,
    FRM_BAD_HEADER,
    FRM_BAD_FLAGS,
    FRM_BAD_END,
    FRM_CUT,
    FRM_NOISE
  } frame_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tuser;   // [0] frame_start
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [3:0] channel_index, [14:4] channel_value, [15] zero
  logic [1:0]  out_tuser;  // [0] frame_ok, [1] failsafe
  logic        out_tlast;

  frame_scoreboard sb;
  int              items_sent;
  bit              no_idle;
  bit              held;
  int              cycle_count;

  sbus_frame_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_tvalid && in_tready)
      sb.take_byte(in_tdata, in_tuser);
  end

  always @(posedge clk) begin
    chan_result_t got;
    if (rst_n === 1'b1 && out_tvalid && out_tready) begin
      got.idx   = out_tdata[3:0];
      got.value = out_tdata[14:4];
      got.ok    = out_tuser[0];
      got.fs    = out_tuser[1];
      got.last  = out_tlast;
      sb.check_channel(got);
    end
  end

  task automatic send_byte(logic [7:0] b, logic st, bit counted);
    while (!no_idle && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= st;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (counted) items_sent++;
    no_idle = (items_sent >= 280 && items_sent < 380);
  endtask

  // A fill of 0 gives all-ones bytes, 1 gives all-zero bytes, anything else random bytes.
  task automatic send_frame(frame_kind_t kind, logic first_start, int fill);
    logic [7:0] fb [FRAME_BYTES];
    int         cut;
    for (int i = 0; i < FRAME_BYTES; i++)
      fb[i] = (fill == 0) ? 8'hff : (fill == 1) ? 8'h00 : 8'($urandom);
    fb[POS_HEADER] = HEADER_VALUE;
    fb[POS_FLAGS]  = fb[POS_FLAGS] & ~FLAG_HIGH_MASK;
    fb[POS_END]    = END_VALUE;
    case (kind)
      FRM_BAD_HEADER: fb[POS_HEADER] = HEADER_VALUE ^ 8'($urandom_range(1, 255));
      FRM_BAD_FLAGS:  fb[POS_FLAGS]  = fb[POS_FLAGS] | (8'($urandom_range(1, 15)) << 4);
      FRM_BAD_END:    fb[POS_END]    = 8'($urandom_range(1, 255));
      default:        ;
    endcase
    // A cut frame stops early; the next frame's start mark restarts decoding mid-frame.
    cut = (kind == FRM_CUT) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
    for (int i = 0; i < cut; i++)
      send_byte(fb[i], (i == 0) ? first_start : 1'b0, 1'b1);
  endtask

  initial begin
    frame_kind_t kind;
    int          pick;
    int          n;
    sb = new();
    items_sent = 0;
    no_idle = 0;
    cycle_count = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tuser  <= 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // After reset the first byte is a header even without a start mark. All-ones data
    // and a full flag nibble give channels at their maximum with failsafe set; the two
    // bytes after the end byte must be ignored.
    send_frame(FRM_GOOD, 1'b0, 0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h0f, 1'b0, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 60)      kind = FRM_GOOD;
      else if (pick < 68) kind = FRM_BAD_HEADER;
      else if (pick < 76) kind = FRM_BAD_FLAGS;
      else if (pick < 84) kind = FRM_BAD_END;
      else if (pick < 92) kind = FRM_CUT;
      else                kind = FRM_NOISE;
      if (kind == FRM_NOISE) begin
        n = $urandom_range(4, 10);
        for (int j = 0; j < n; j++)
          send_byte(8'($urandom), (j == 0) || ($urandom_range(9) == 0), 1'b1);
      end else begin
        send_frame(kind, 1'b1, $urandom_range(9));
        if (kind != FRM_CUT && $urandom_range(3) == 0) begin
          n = $urandom_range(1, 3);
          for (int j = 0; j < n; j++)
            send_byte(8'($urandom), 1'b0, 1'b0);
        end
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Checked %0d channel results from %0d good and %0d bad frames.",
             sb.results_checked, sb.good_frames, sb.bad_frames);
    $display("Fed %0d bytes, %0d of them stray bytes outside any frame.",
             sb.bytes_taken, sb.ignored_bytes);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off once traffic is flowing so
  // that the output burst backs up and the decoder has to stall its input.
  initial begin
    held = 0;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held && sb.bytes_taken >= 100) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= no_idle || ($urandom_range(99) >= 36);
    end
  end

endmodule

>>> sim.f
hdl/sfd_pkg.sv
hdl/sfd_unpack.sv
hdl/sfd_emit.sv
hdl/sbus_frame_decoder_top.sv
bench/sfd_scoreboard_pkg.sv
bench/tb_sbus_frame_decoder_top.sv
